// ----- design/mf3_pkg.sv -----
package mf3_pkg;

	// Default build limits
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int PIXEL_BITS_DEF = 8;

	// Register file
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 13;
	localparam int CFG_W_BITS     = 11;
	localparam int CFG_H_BITS     = 13;
	localparam int RESET_WIDTH    = 640;
	localparam int RESET_HEIGHT   = 480;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	// Queue depths
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 16;

	// Per-item control decided by the front end
	typedef struct packed {
		logic emit;       // item completes a neighborhood
		logic last;       // that neighborhood is the frame's last pixel
		logic col_zero;   // input column is 0
		logic col_one;    // input column is 1
		logic top_clamp;  // center row is row 0
		logic bot_clamp;  // center row is the last row
		logic w_one;      // image is one column wide
	} work_flags_t;

	// Median-of-9 compare-exchange network, one layer per stage.
	// Pair (a,b): min goes to a, max to b. (0,0) pads unused slots.
	localparam int SORT_LAYERS = 9;
	localparam int SORT_PAIRS  = 3;
	localparam int NBR         = 9;
	localparam int MED_SLOT    = 4;

	localparam int SORT_A [SORT_LAYERS][SORT_PAIRS] = '{
		'{1, 4, 7},
		'{0, 3, 6},
		'{1, 4, 7},
		'{0, 5, 4},
		'{3, 1, 2},
		'{4, 0, 0},
		'{4, 0, 0},
		'{6, 0, 0},
		'{4, 0, 0}
	};
	localparam int SORT_B [SORT_LAYERS][SORT_PAIRS] = '{
		'{2, 5, 8},
		'{1, 4, 7},
		'{2, 5, 8},
		'{3, 8, 7},
		'{6, 4, 5},
		'{7, 0, 0},
		'{2, 0, 0},
		'{4, 0, 0},
		'{2, 0, 0}
	};

endpackage

// ----- design/mf3_ram.sv -----
module mf3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read-first: a read and write to one address in a cycle returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/mf3_fifo.sv -----
module mf3_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push, do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- design/mf3_front.sv -----
module mf3_front #(
	parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF,
	parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [mf3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mf3_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               push,
	input  logic                               operation,
	input  logic [PIXEL_BITS-1:0]              pixel,
	input  logic                               q_full,
	output logic                               q_push,
	output logic [$clog2(MAX_WIDTH)-1:0]       q_col,
	output logic [PIXEL_BITS-1:0]              q_pixel,
	output mf3_pkg::work_flags_t               q_flags
);

	import mf3_pkg::*;

	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int HGT_BITS = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_BITS = $clog2(MAX_HEIGHT + 2);
	localparam int RST_W    = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int RST_H    = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

	logic [COL_BITS-1:0] in_col_q, w_m1_q, w_m1_d;
	logic [ROW_BITS-1:0] in_row_q, h_ext;
	logic [HGT_BITS-1:0] h_q, h_d;
	logic [31:0]         cfg_w32, cfg_h32;
	logic                drain, accept;

	// clamp register writes into 1..MAX
	always_comb begin
		cfg_w32 = 32'(cfg_data[CFG_W_BITS-1:0]);
		cfg_h32 = 32'(cfg_data[CFG_H_BITS-1:0]);
		if (cfg_w32 == 32'd0) begin
			w_m1_d = '0;
		end else if (cfg_w32 > 32'(MAX_WIDTH)) begin
			w_m1_d = COL_BITS'(MAX_WIDTH - 1);
		end else begin
			w_m1_d = COL_BITS'(cfg_w32 - 32'd1);
		end
		if (cfg_h32 == 32'd0) begin
			h_d = HGT_BITS'(1);
		end else if (cfg_h32 > 32'(MAX_HEIGHT)) begin
			h_d = HGT_BITS'(MAX_HEIGHT);
		end else begin
			h_d = HGT_BITS'(cfg_h32);
		end
	end

	assign h_ext  = ROW_BITS'(h_q);
	assign drain  = (in_row_q >= h_ext);
	assign accept = push && !q_full;
	// a flush before the frame's pixels are all in is dropped
	assign q_push = accept && !(operation && !drain);

	assign q_col   = in_col_q;
	assign q_pixel = drain ? '0 : pixel;

	always_comb begin
		q_flags.last      = (in_row_q > h_ext);
		q_flags.emit      = (in_row_q >= ROW_BITS'(2)) ||
		                    ((in_row_q == ROW_BITS'(1)) && (in_col_q != '0));
		q_flags.col_zero  = (in_col_q == '0);
		q_flags.col_one   = (in_col_q == COL_BITS'(1));
		q_flags.top_clamp = (in_row_q == ROW_BITS'(1));
		q_flags.bot_clamp = (in_row_q == h_ext);
		q_flags.w_one     = (w_m1_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_m1_q   <= COL_BITS'(RST_W - 1);
			h_q      <= HGT_BITS'(RST_H);
			in_col_q <= '0;
			in_row_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					w_m1_q   <= w_m1_d;
					in_col_q <= '0;
					in_row_q <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					h_q      <= h_d;
					in_col_q <= '0;
					in_row_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (q_push) begin
			if (q_flags.last) begin
				in_col_q <= '0;
				in_row_q <= '0;
			end else if (in_col_q == w_m1_q) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + 1'b1;
			end else begin
				in_col_q <= in_col_q + 1'b1;
			end
		end
	end

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= h_ext + ROW_BITS'(1))
		else $error("input row ran past the drain row");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_col_q <= w_m1_q)
		else $error("input column past image width");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_flags.last |-> q_flags.emit)
		else $error("frame end on an item with no output");

endmodule

// ----- design/mf3_back.sv -----
module mf3_back #(
	parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
	input  logic [PIXEL_BITS-1:0]        q_pixel,
	input  mf3_pkg::work_flags_t         q_flags,
	output logic                         q_pop,
	input  logic                         pop,
	output logic                         empty,
	output logic [PIXEL_BITS-1:0]        median,
	output logic                         last_in_frame
);

	import mf3_pkg::*;

	localparam int COL_BITS  = $clog2(MAX_WIDTH);
	localparam int PEND_BITS = $clog2(OUT_DEPTH + 1);
	localparam int PB        = PIXEL_BITS;

	// ---- stage 1: line RAM read, column vector, window assembly ----
	logic                item_valid_s1;
	logic [COL_BITS-1:0] col_s1;
	logic [PB-1:0]       pix_s1;
	work_flags_t         flags_s1;

	logic [2*PB-1:0] ram_rdata, ram_wdata, byp_data_q, line_word;
	logic            byp_q;
	logic [PB-1:0]   row_a, row_b;
	logic [PB-1:0]   vec [3];
	logic [PB-1:0]   x1_q [3];
	logic [PB-1:0]   x2_q [3];
	logic [PB-1:0]   win [NBR];

	logic [PB-1:0] win_s2 [NBR];
	logic          valid_s2, last_s2;

	logic [PB-1:0] sort_q [SORT_LAYERS+1][NBR];
	logic          sort_vld_q [SORT_LAYERS+1];
	logic          sort_lst_q [SORT_LAYERS+1];

	logic [PEND_BITS-1:0] pending_q;
	logic                 out_push, out_full, out_pop;
	logic [PB:0]          out_rdata;

	// only take work when its result is sure to find room in the output queue
	assign q_pop = !q_empty && (pending_q < PEND_BITS'(OUT_DEPTH));

	// word per column: upper half two rows back, lower half one row back
	mf3_ram #(
		.WIDTH(2 * PB),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (item_valid_s1),
		.waddr(col_s1),
		.wdata(ram_wdata),
		.raddr(q_col),
		.rdata(ram_rdata)
	);

	// back-to-back hit on one column (one-column images) bypasses the RAM
	assign line_word = byp_q ? byp_data_q : ram_rdata;
	assign row_a     = line_word[PB-1:0];
	assign row_b     = line_word[2*PB-1:PB];
	assign ram_wdata = {row_a, pix_s1};

	always_comb begin
		vec[1] = row_a;
		vec[0] = flags_s1.top_clamp ? row_a : row_b;
		vec[2] = flags_s1.bot_clamp ? row_a : pix_s1;
		for (int r = 0; r < 3; r++) begin
			win[3 + r] = x1_q[r];
			if (!flags_s1.col_zero) begin
				win[r]     = flags_s1.col_one ? x1_q[r] : x2_q[r];
				win[6 + r] = vec[r];
			end else begin
				// right edge of the previous row: last column repeats
				win[r]     = flags_s1.w_one ? x1_q[r] : x2_q[r];
				win[6 + r] = x1_q[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			byp_q         <= 1'b0;
			valid_s2      <= 1'b0;
		end else begin
			item_valid_s1 <= q_pop;
			byp_q         <= item_valid_s1 && q_pop && (q_col == col_s1);
			valid_s2      <= item_valid_s1 && flags_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			col_s1   <= q_col;
			pix_s1   <= q_pixel;
			flags_s1 <= q_flags;
		end
		byp_data_q <= ram_wdata;
		if (item_valid_s1) begin
			x2_q    <= x1_q;
			x1_q    <= vec;
			win_s2  <= win;
			last_s2 <= flags_s1.last;
		end
	end

	// ---- stages 2..10: compare-exchange network ----
	assign sort_q[0]     = win_s2;
	assign sort_vld_q[0] = valid_s2;
	assign sort_lst_q[0] = last_s2;

	for (genvar i = 0; i < SORT_LAYERS; i++) begin : g_layer
		logic [PB-1:0] nxt [NBR];

		always_comb begin
			nxt = sort_q[i];
			for (int p = 0; p < SORT_PAIRS; p++) begin
				if (sort_q[i][SORT_A[i][p]] > sort_q[i][SORT_B[i][p]]) begin
					nxt[SORT_A[i][p]] = sort_q[i][SORT_B[i][p]];
					nxt[SORT_B[i][p]] = sort_q[i][SORT_A[i][p]];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sort_vld_q[i+1] <= 1'b0;
			end else begin
				sort_vld_q[i+1] <= sort_vld_q[i];
			end
		end

		always_ff @(posedge clk) begin
			sort_q[i+1]     <= nxt;
			sort_lst_q[i+1] <= sort_lst_q[i];
		end
	end

	// ---- output queue ----
	assign out_push = sort_vld_q[SORT_LAYERS];
	assign out_pop  = pop && !empty;

	mf3_fifo #(
		.WIDTH(PB + 1),
		.DEPTH(OUT_DEPTH)
	) u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata ({sort_lst_q[SORT_LAYERS], sort_q[SORT_LAYERS][MED_SLOT]}),
		.pop   (pop),
		.rdata (out_rdata),
		.full  (out_full),
		.empty (empty)
	);

	assign median        = out_rdata[PB-1:0];
	assign last_in_frame = out_rdata[PB];

	// results in flight plus results waiting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			if ((q_pop && q_flags.emit) && !out_pop) begin
				pending_q <= pending_q + 1'b1;
			end else if (out_pop && !(q_pop && q_flags.emit)) begin
				pending_q <= pending_q - 1'b1;
			end
		end
	end

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PEND_BITS'(OUT_DEPTH))
		else $error("credit count overflow");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("median arrived at a full output queue");

endmodule

// ----- design/median_filter_3x3_top.sv -----
// A result comes from the item that completes its neighborhood (image_width + 1
//   items after the pixel), which passes the back-end pipeline and output queue.
// Throughput: one item per clock through the pipelined sort, unless pop stalls.
// Reset (arst_n low, asynchronous): positions clear, width/height return to 640x480,
//   both queues empty. Line RAM is not cleared and needs no clearing pass.
module median_filter_3x3_top #(
	parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF,
	parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input queue side
	input  logic                               push,
	output logic                               full,
	input  logic                               operation,
	input  logic [PIXEL_BITS-1:0]              pixel,
	// result queue side
	output logic                               empty,
	input  logic                               pop,
	output logic [PIXEL_BITS-1:0]              median,
	output logic                               last_in_frame,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mf3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mf3_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	import mf3_pkg::*;

	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int FLG_BITS = $bits(work_flags_t);
	localparam int MQ_BITS  = COL_BITS + PIXEL_BITS + FLG_BITS;

	// Front end -> work queue
	logic                  fe_push;
	logic [COL_BITS-1:0]   fe_col;
	logic [PIXEL_BITS-1:0] fe_pixel;
	work_flags_t           fe_flags;

	// Work queue -> back end
	logic                  mq_full, mq_empty, mq_pop;
	logic [MQ_BITS-1:0]    mq_rdata;
	logic [COL_BITS-1:0]   mq_col;
	logic [PIXEL_BITS-1:0] mq_pixel;
	work_flags_t           mq_flags;

	// Register writes are not checked; the user must issue them only while idle.
	assign cfg_ready = 1'b1;

	// The input transaction completes whenever the work queue has room, so
	// full is simply the queue's full flag.
	assign full = mq_full;

	// Front end: holds width/height, tracks the raster position, drops early
	// flushes, turns late pixels into drain ticks and tags each item with the
	// flags the back end needs (edge clamps, emit, frame end).
	mf3_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.PIXEL_BITS(PIXEL_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.operation(operation),
		.pixel    (pixel),
		.q_full   (mq_full),
		.q_push   (fe_push),
		.q_col    (fe_col),
		.q_pixel  (fe_pixel),
		.q_flags  (fe_flags)
	);

	// Short work queue: decouples input acceptance from back-end stalls.
	mf3_fifo #(
		.WIDTH(MQ_BITS),
		.DEPTH(MID_DEPTH)
	) u_work_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fe_push),
		.wdata ({fe_col, fe_pixel, fe_flags}),
		.pop   (mq_pop),
		.rdata (mq_rdata),
		.full  (mq_full),
		.empty (mq_empty)
	);

	assign {mq_col, mq_pixel, mq_flags} = mq_rdata;

	// Back end: line RAM (two rows per column word), 3x3 window, nine-layer
	// compare-exchange pipeline and the output queue. It pulls work only when
	// the output queue has a free slot reserved for every result in flight,
	// so once an item enters the pipeline it never stalls.
	mf3_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (mq_empty),
		.q_col        (mq_col),
		.q_pixel      (mq_pixel),
		.q_flags      (mq_flags),
		.q_pop        (mq_pop),
		.pop          (pop),
		.empty        (empty),
		.median       (median),
		.last_in_frame(last_in_frame)
	);

endmodule

// ----- test/median_filter_3x3_top_tb.sv -----
module median_filter_3x3_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mf3_pkg::*;

	// Pixel history ring: two line stores plus the two pixels of overlap.
	localparam int HIST_DEPTH = 2 * MAX_WIDTH_DEF + 2;
	// Idle cycles before a register write. The block may still be busy on
	// items that produce no result, so allow well over its pipeline latency.
	localparam int LATENCY_GUARD = 40;
	localparam int CYCLE_LIMIT = 1000000;

	// Input operation codes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Register indexes past the end of the register file. Writes to them
	// must leave the block alone.
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [7:0] med;
		logic       last;
	} filtered_pixel_t;

	// Tracks the filter state and holds the medians still owed by the block.
	class median_scoreboard;
		logic [CFG_W_BITS-1:0] width_reg;
		logic [CFG_H_BITS-1:0] height_reg;
		logic [7:0]            history[HIST_DEPTH];
		int                    hist_pos;
		int                    in_col, in_row, out_col, out_row;
		filtered_pixel_t       owed_medians[$];
		int                    taken;
		int                    failures;

		function new();
			width_reg  = CFG_W_BITS'(RESET_WIDTH);
			height_reg = CFG_H_BITS'(RESET_HEIGHT);
			hist_pos   = 0;
			taken      = 0;
			failures   = 0;
			foreach (history[i]) history[i] = '0;
			restart();
		endfunction

		function void restart();
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
		endfunction

		function int eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
			return int'(width_reg);
		endfunction

		function int eff_height();
			if (height_reg == 0) return 1;
			if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
			return int'(height_reg);
		endfunction

		function int pending();
			return owed_medians.size();
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			if (idx == REG_IMAGE_WIDTH) begin
				width_reg = data[CFG_W_BITS-1:0];
			end else if (idx == REG_IMAGE_HEIGHT) begin
				height_reg = data[CFG_H_BITS-1:0];
			end else begin
				return;
			end
			restart();
		endfunction

		function int clamp(int v, int hi);
			if (v < 0) return 0;
			if (v > hi) return hi;
			return v;
		endfunction

		function logic [7:0] median9(logic [7:0] nbr[9]);
			logic [7:0] s[9];
			logic [7:0] v;
			int         j;
			s = nbr;
			for (int i = 1; i < 9; i++) begin
				v = s[i];
				j = i;
				while (j > 0 && s[j-1] > v) begin
					s[j] = s[j-1];
					j--;
				end
				s[j] = v;
			end
			return s[4];
		endfunction

		function void flag(string msg);
			if (failures < 10) $display("%s", msg);
			failures++;
		endfunction

		// One accepted input transaction.
		function void note_item(logic op, logic [7:0] pix_in);
			int         w, h, k, total, rr, cc, d, slot, dr, dc;
			logic [7:0] pix;
			logic [7:0] nbr[9];
			logic       emit, last;
			w     = eff_width();
			h     = eff_height();
			k     = in_row * w + in_col;
			total = w * h;
			pix   = pix_in;
			emit  = 1'b0;
			last  = 1'b0;
			// flush inside the frame is dropped; past the frame every item is a zero
			if (k < total) begin
				if (op == OP_FLUSH) return;
			end else begin
				pix = '0;
			end
			taken++;
			if (k >= w + 1) begin
				slot = 0;
				for (dr = -1; dr <= 1; dr++) begin
					for (dc = -1; dc <= 1; dc++) begin
						rr = clamp(out_row + dr, h - 1);
						cc = clamp(out_col + dc, w - 1);
						d  = k - (rr * w + cc);
						if (d <= 0) begin
							nbr[slot] = pix;
						end else begin
							if (d > HIST_DEPTH) d = HIST_DEPTH;
							nbr[slot] = history[(hist_pos + HIST_DEPTH - d) % HIST_DEPTH];
						end
						slot++;
					end
				end
				emit = 1'b1;
				last = (out_row == h - 1) && (out_col == w - 1);
				owed_medians.push_back('{med: median9(nbr), last: last});
			end
			history[hist_pos] = pix;
			hist_pos = (hist_pos + 1) % HIST_DEPTH;
			if (emit && last) begin
				restart();
				return;
			end
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (emit) begin
				out_col++;
				if (out_col >= w) begin
					out_col = 0;
					out_row++;
				end
			end
		endfunction

		// One accepted result transaction.
		function void check_result(logic [7:0] med, logic last);
			filtered_pixel_t want;
			if (owed_medians.size() == 0) begin
				flag($sformatf("unexpected result: median %0d last %0b", med, last));
				return;
			end
			want = owed_medians.pop_front();
			if (med !== want.med)
				flag($sformatf("median mismatch: expected %0d got %0d", want.med, med));
			if (last !== want.last)
				flag($sformatf("last_in_frame mismatch: expected %0b got %0b", want.last, last));
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      push = 1'b0;
	logic                      full;
	logic                      operation = 1'b0;
	logic [7:0]                pixel = '0;
	logic                      empty;
	logic                      pop = 1'b0;
	logic [7:0]                median;
	logic                      last_in_frame;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	median_scoreboard sb = new();

	int burst_left = 0;  // sender transactions left before the next gap
	int pop_left = 0;    // cycles left in the current receiver pattern step
	int cycles = 0;

	median_filter_3x3_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.operation     (operation),
		.pixel         (pixel),
		.empty         (empty),
		.pop           (pop),
		.median        (median),
		.last_in_frame (last_in_frame),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Hard stop in case the block hangs or drops results.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: checks each popped result, then picks the next pop pattern
	// step. Long runs of steady pop mix with short toggling stalls.
	always @(posedge clk) begin
		if (arst_n && pop && empty === 1'b0)
			sb.check_result(median, last_in_frame);
		if (pop_left > 0) begin
			pop_left--;
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					pop <= 1'b1;
					pop_left = $urandom_range(32, 64);
				end
				3, 4, 5, 6: begin
					pop <= 1'b1;
					pop_left = $urandom_range(0, 5);
				end
				default: begin
					pop <= 1'b0;
					pop_left = $urandom_range(0, 9);
				end
			endcase
		end
	end

	// Random bytes half the time, else the extremes or a narrow mid-gray band so
	// that the sort sees ties and near ties.
	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'($urandom_range(120, 135));
			default: return 8'($urandom);
		endcase
	endfunction

	// Sender: one input transaction, then a random gap at the end of a burst.
	// push stays high across back-to-back transactions.
	task automatic send_item(logic op, logic [7:0] pix);
		int gap;
		push      <= 1'b1;
		operation <= op;
		pixel     <= pix;
		do @(posedge clk); while (full !== 1'b0);
		sb.note_item(op, pix);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
			                                         : $urandom_range(0, 15);
			gap = $urandom_range(1, 8);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Holds the sender until every owed median has come back.
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Drained and quiet: safe point for register writes and the end of the run.
	task automatic settle();
		wait_drained();
		repeat (LATENCY_GUARD) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(logic [CFG_DATA_BITS-1:0] w_raw, logic [CFG_DATA_BITS-1:0] h_raw);
		settle();
		if ($urandom_range(0, 1)) begin
			write_reg(REG_IMAGE_WIDTH, w_raw);
			write_reg(REG_IMAGE_HEIGHT, h_raw);
		end else begin
			write_reg(REG_IMAGE_HEIGHT, h_raw);
			write_reg(REG_IMAGE_WIDTH, w_raw);
		end
		if ($urandom_range(0, 2) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_BITS'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One frame of random content with stray flushes inside it, then the
	// w+1 drain ticks (some of them real pixels, which count as flushes).
	// A truncated frame stops partway; the next register write restarts it.
	task automatic run_frame(logic truncate);
		int w, total, cut;
		w     = sb.eff_width();
		total = w * sb.eff_height();
		cut   = truncate ? $urandom_range(0, total - 1) : total;
		for (int i = 0; i < cut; i++) begin
			if ($urandom_range(0, 11) == 0) send_item(OP_FLUSH, 8'($urandom));
			send_item(OP_PIXEL, pick_pixel());
			if ($urandom_range(0, 199) == 0) wait_drained();
		end
		if (truncate) return;
		for (int j = 0; j <= w; j++) begin
			if ($urandom_range(0, 3) == 0) send_item(OP_PIXEL, 8'($urandom));
			else send_item(OP_FLUSH, 8'($urandom));
		end
		// a flush right at the start of the next frame is dropped
		if ($urandom_range(0, 3) == 0) send_item(OP_FLUSH, 8'($urandom));
	endtask

	function automatic logic [CFG_DATA_BITS-1:0] pick_width();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return CFG_DATA_BITS'(($urandom_range(1, 3) << CFG_W_BITS) | $urandom_range(0, 6));
			default: return CFG_DATA_BITS'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pick_height();
		return ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_BITS'($urandom_range(1, 5));
	endfunction

	initial begin
		int  random_start;
		int  frames;
		logic cut;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Reset geometry (640x480): the first row is still filling, so no
		// median may come out yet.
		for (int i = 0; i < 40; i++) send_item(OP_PIXEL, pick_pixel());

		// Directed 3x3 frame; the width write carries bits above the field.
		configure(13'h1803, 13'd3);
		send_item(OP_FLUSH, 8'hFF);   // flush inside frame: dropped
		send_item(OP_PIXEL, 8'h00);
		send_item(OP_PIXEL, 8'hFF);
		send_item(OP_PIXEL, 8'h80);
		send_item(OP_PIXEL, 8'hFF);
		send_item(OP_PIXEL, 8'h00);
		send_item(OP_PIXEL, 8'hFF);
		wait_drained();               // sender pause with the frame half done
		send_item(OP_FLUSH, 8'h5A);   // dropped again
		send_item(OP_PIXEL, 8'h01);
		send_item(OP_PIXEL, 8'hFE);
		send_item(OP_PIXEL, 8'h7F);
		send_item(OP_FLUSH, 8'h00);   // drain
		send_item(OP_PIXEL, 8'hAA);   // pixel during drain acts as a flush
		send_item(OP_FLUSH, 8'h00);
		send_item(OP_FLUSH, 8'h00);   // carries last_in_frame
		send_item(OP_FLUSH, 8'h33);   // start of the next frame: dropped

		// Out-of-range indexes, then zero width/height (both taken as 1).
		settle();
		write_reg(REG_SPARE_A, 13'h1FFF);
		write_reg(REG_SPARE_B, 13'h0000);
		write_reg(REG_IMAGE_WIDTH, 13'd0);
		write_reg(REG_IMAGE_HEIGHT, 13'd0);
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_item(OP_PIXEL, 8'hC3);
		send_item(OP_PIXEL, 8'h3C);
		send_item(OP_FLUSH, 8'h00);

		// Random small geometries, a few frames each.
		random_start = sb.taken;
		while (sb.taken - random_start < 250) begin
			configure(pick_width(), pick_height());
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				cut = ($urandom_range(0, 7) == 0);
				run_frame(cut);
				if (cut) break;
			end
		end

		// Geometry extremes on partial frames: width 2047 clamps to the
		// maximum (first row still filling, nothing comes out), and height
		// 8191 clamps to the maximum on a one-column image.
		configure(13'd2047, 13'd2);
		for (int i = 0; i < 30; i++) send_item(OP_PIXEL, pick_pixel());
		configure(13'd0, 13'h1FFF);
		for (int i = 0; i < 30; i++) send_item(OP_PIXEL, pick_pixel());

		settle();
		if (sb.failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
